// ----- rtl/pbv_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// pbv_pkg: shared types and constants of the protobuf wire validator
// Field widths, status codes, register indexes, register reset values, wire types and parse phases.
// ---------------------------------------------------------------------------
package pbv_pkg;

   // field widths
   localparam int unsigned DATA_W   = 8;
   localparam int unsigned LEN_W    = 32;
   localparam int unsigned FIELDS_W = 16;
   localparam int unsigned ACC_W    = 64;
   localparam int unsigned IDX_W    = 4;
   localparam int unsigned CSR_IDX_W = 2;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_NOT_CHECKED = 2'd0,
      STATUS_INVALID     = 2'd1,
      STATUS_VALID       = 2'd2
   } status_type;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MAX_FRAME_BYTES      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_DELIMITED_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_FIELDS           = 2'd2;

   // register reset values
   localparam logic [LEN_W-1:0]    RST_MAX_FRAME_BYTES      = 32'd8388608;
   localparam logic [LEN_W-1:0]    RST_MAX_DELIMITED_LENGTH = 32'd8388608;
   localparam logic [FIELDS_W-1:0] RST_MAX_FIELDS           = 16'd10000;

   // wire types
   localparam logic [2:0] WT_VARINT    = 3'd0;
   localparam logic [2:0] WT_FIXED64   = 3'd1;
   localparam logic [2:0] WT_DELIMITED = 3'd2;
   localparam logic [2:0] WT_FIXED32   = 3'd5;

   localparam logic [LEN_W-1:0] HEADER_BYTES  = 32'd4;
   localparam logic [LEN_W-1:0] FIXED64_BYTES = 32'd8;
   localparam logic [LEN_W-1:0] FIXED32_BYTES = 32'd4;
   localparam logic [IDX_W-1:0] VARINT_LAST_IDX = 4'd9;

   // parse phases, one-hot
   typedef enum logic [5:0] {
      PH_HEADER = 6'b000001,
      PH_TAG    = 6'b000010,
      PH_VALUE  = 6'b000100,
      PH_LEN    = 6'b001000,
      PH_SKIP   = 6'b010000,
      PH_ERROR  = 6'b100000
   } phase_type;

endpackage
`default_nettype wire

// ----- rtl/protobuf_wire_validator.sv -----
`default_nettype none
// Path: a byte transfer lands in the input register and is checked from there;
//   the result of a checked last byte is loaded into the output register.
// Throughput: one byte per cycle; a last byte waits only while the previous result is held.
// Reset: synchronous, active high; clears the frame state and loads the register defaults.
// ---------------------------------------------------------------------------
// protobuf_wire_validator: per-frame protobuf wire format check
// Reads a little-endian declared length, then walks the declared region
// field by field and reports one status on the last byte of every frame.
// ---------------------------------------------------------------------------
module protobuf_wire_validator (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [pbv_pkg::DATA_W-1:0]      req_data_byte,
   input  wire logic                            req_last_byte,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [1:0]                           rsp_status,
   output logic [pbv_pkg::LEN_W-1:0]            rsp_declared_length,
   input  wire logic                            csr_write_enable,
   input  wire logic [pbv_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [pbv_pkg::LEN_W-1:0]       csr_write_data
);
   import pbv_pkg::*;

   // configuration registers
   logic [LEN_W-1:0]    max_frame_ff;
   logic [LEN_W-1:0]    max_delim_ff;
   logic [FIELDS_W-1:0] max_fields_ff;

   // input register
   logic                in_valid_ff, in_valid_in;
   logic [DATA_W-1:0]   in_byte_ff;
   logic                in_last_ff;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [LEN_W-1:0]    rsp_len_ff, rsp_len_in;

   // frame state
   phase_type           phase_ff, phase_in, phase_upd;
   logic [LEN_W-1:0]    count_ff, count_in, count_upd;
   logic [LEN_W-1:0]    length_ff, length_in, length_upd;
   logic [LEN_W-1:0]    consumed_ff, consumed_in, consumed_upd;
   logic [ACC_W-1:0]    acc_ff, acc_in, acc_upd;
   logic [IDX_W-1:0]    idx_ff, idx_in, idx_upd;
   logic [LEN_W-1:0]    skip_ff, skip_in, skip_upd;
   logic [FIELDS_W-1:0] fields_ff, fields_in, fields_upd;
   logic                error_ff, error_in, error_upd;

   // handshake
   logic                out_free;
   logic                proc;
   logic                req_fire;

   // datapath helpers
   logic [LEN_W-1:0]    consumed_inc;
   logic [LEN_W-1:0]    rem;
   logic [6:0]          var_shamt;
   logic [ACC_W-1:0]    acc_val;
   logic                v_over_rem;
   logic                v_over_delim;
   logic                v_nonzero;
   logic [LEN_W-1:0]    hdr_part;

   // pipeline flow: a byte advances when it needs no result slot or the slot is free
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign proc      = in_valid_ff && (!in_last_ff || out_free);
   assign req_ready = !in_valid_ff || proc;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (proc) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // varint accumulation and length checks
   assign consumed_inc = consumed_ff + 32'd1;
   assign rem          = length_ff - consumed_inc;
   assign var_shamt    = {idx_ff, 3'b000} - {3'b000, idx_ff};
   assign acc_val      = acc_ff | ({{(ACC_W-7){1'b0}}, in_byte_ff[6:0]} << var_shamt);
   assign v_over_rem   = (|acc_val[63:32]) || (acc_val[31:0] > rem);
   assign v_over_delim = (|acc_val[63:32]) || (acc_val[31:0] > max_delim_ff);
   assign v_nonzero    = |acc_val;
   assign hdr_part     = {24'd0, in_byte_ff} << {count_ff[1:0], 3'b000};

   // per-byte parse step
   always_comb begin
      phase_upd    = phase_ff;
      count_upd    = count_ff;
      length_upd   = length_ff;
      consumed_upd = consumed_ff;
      acc_upd      = acc_ff;
      idx_upd      = idx_ff;
      skip_upd     = skip_ff;
      fields_upd   = fields_ff;
      error_upd    = error_ff;

      if (count_ff != '1) begin
         count_upd = count_ff + 32'd1;
      end

      if (count_ff < HEADER_BYTES) begin
         // collect the declared length
         length_upd = length_ff | hdr_part;
         if (count_ff[1:0] == 2'd3) begin
            phase_upd = PH_TAG;
         end
      end else if (consumed_ff < length_ff && phase_ff != PH_ERROR) begin
         if (phase_ff == PH_TAG && idx_ff == '0 && fields_ff >= max_fields_ff) begin
            // field limit reached at the start of a new field
            error_upd = 1'b1;
            phase_upd = PH_ERROR;
         end else begin
            if (phase_ff == PH_TAG && idx_ff == '0) begin
               fields_upd = fields_ff + 16'd1;
            end
            consumed_upd = consumed_inc;
            if (phase_ff == PH_SKIP) begin
               // skip payload bytes
               skip_upd = skip_ff - 32'd1;
               if (skip_ff == 32'd1) begin
                  phase_upd = PH_TAG;
               end
            end else if (in_byte_ff[7]) begin
               // varint continues
               acc_upd = acc_val;
               idx_upd = idx_ff + 4'd1;
               if (idx_ff == VARINT_LAST_IDX) begin
                  error_upd = 1'b1;
                  phase_upd = PH_ERROR;
               end
            end else begin
               // varint complete: act on its value
               acc_upd = '0;
               idx_upd = '0;
               case (phase_ff)
                  PH_TAG: begin
                     if (!v_nonzero) begin
                        error_upd = 1'b1;
                        phase_upd = PH_ERROR;
                     end else begin
                        case (acc_val[2:0])
                           WT_VARINT: begin
                              phase_upd = PH_VALUE;
                           end
                           WT_FIXED64: begin
                              if (rem < FIXED64_BYTES) begin
                                 error_upd = 1'b1;
                                 phase_upd = PH_ERROR;
                              end else begin
                                 skip_upd  = FIXED64_BYTES;
                                 phase_upd = PH_SKIP;
                              end
                           end
                           WT_DELIMITED: begin
                              phase_upd = PH_LEN;
                           end
                           WT_FIXED32: begin
                              if (rem < FIXED32_BYTES) begin
                                 error_upd = 1'b1;
                                 phase_upd = PH_ERROR;
                              end else begin
                                 skip_upd  = FIXED32_BYTES;
                                 phase_upd = PH_SKIP;
                              end
                           end
                           default: begin
                              error_upd = 1'b1;
                              phase_upd = PH_ERROR;
                           end
                        endcase
                     end
                  end
                  PH_VALUE: begin
                     phase_upd = PH_TAG;
                  end
                  PH_LEN: begin
                     if (v_over_rem || v_over_delim) begin
                        error_upd = 1'b1;
                        phase_upd = PH_ERROR;
                     end else if (!v_nonzero) begin
                        phase_upd = PH_TAG;
                     end else begin
                        skip_upd  = acc_val[31:0];
                        phase_upd = PH_SKIP;
                     end
                  end
                  default: begin
                     phase_upd = phase_ff;
                  end
               endcase
            end
         end
      end
   end

   // frame verdict on the last byte
   always_comb begin
      if (count_upd < HEADER_BYTES) begin
         rsp_status_in = STATUS_NOT_CHECKED;
         rsp_len_in    = '0;
      end else begin
         rsp_len_in = length_upd;
         if (count_upd > max_frame_ff || length_upd > (count_upd - HEADER_BYTES)) begin
            rsp_status_in = STATUS_NOT_CHECKED;
         end else if (!error_upd && phase_upd == PH_TAG && idx_upd == '0 &&
                      consumed_upd == length_upd) begin
            rsp_status_in = STATUS_VALID;
         end else begin
            rsp_status_in = STATUS_INVALID;
         end
      end
   end

   // commit the step; drop frame state after the last byte
   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      length_in   = length_ff;
      consumed_in = consumed_ff;
      acc_in      = acc_ff;
      idx_in      = idx_ff;
      skip_in     = skip_ff;
      fields_in   = fields_ff;
      error_in    = error_ff;
      if (proc) begin
         if (in_last_ff) begin
            phase_in    = PH_HEADER;
            count_in    = '0;
            length_in   = '0;
            consumed_in = '0;
            acc_in      = '0;
            idx_in      = '0;
            skip_in     = '0;
            fields_in   = '0;
            error_in    = 1'b0;
         end else begin
            phase_in    = phase_upd;
            count_in    = count_upd;
            length_in   = length_upd;
            consumed_in = consumed_upd;
            acc_in      = acc_upd;
            idx_in      = idx_upd;
            skip_in     = skip_upd;
            fields_in   = fields_upd;
            error_in    = error_upd;
         end
      end
   end

   // result slot: load on a checked last byte, release on transfer
   always_comb begin
      if (proc && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control and frame state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         phase_ff      <= PH_HEADER;
         count_ff      <= '0;
         length_ff     <= '0;
         consumed_ff   <= '0;
         acc_ff        <= '0;
         idx_ff        <= '0;
         skip_ff       <= '0;
         fields_ff     <= '0;
         error_ff      <= 1'b0;
         max_frame_ff  <= RST_MAX_FRAME_BYTES;
         max_delim_ff  <= RST_MAX_DELIMITED_LENGTH;
         max_fields_ff <= RST_MAX_FIELDS;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         length_ff    <= length_in;
         consumed_ff  <= consumed_in;
         acc_ff       <= acc_in;
         idx_ff       <= idx_in;
         skip_ff      <= skip_in;
         fields_ff    <= fields_in;
         error_ff     <= error_in;
         if (csr_write_enable) begin
            case (csr_index)
               REG_MAX_FRAME_BYTES: begin
                  max_frame_ff <= csr_write_data;
               end
               REG_MAX_DELIMITED_LENGTH: begin
                  max_delim_ff <= csr_write_data;
               end
               REG_MAX_FIELDS: begin
                  max_fields_ff <= csr_write_data[FIELDS_W-1:0];
               end
               default: begin
                  max_frame_ff <= max_frame_ff;
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
      if (proc && in_last_ff) begin
         rsp_status_ff <= rsp_status_in;
         rsp_len_ff    <= rsp_len_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_declared_length = rsp_len_ff;

`ifndef SYNTH
   // a last byte waiting on a full result slot blocks new transfers
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && in_last_ff && rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("input taken while last byte is stalled");

   // frame state is cleared after a last byte is checked
   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      (proc && in_last_ff) |=> (count_ff == '0 && phase_ff == PH_HEADER))
      else $error("frame state not cleared after last byte");

   // the error flag and the error phase travel together
   a_error_phase: assert property (@(posedge clock) disable iff (reset)
      error_ff == (phase_ff == PH_ERROR))
      else $error("error flag and phase disagree");

   // only the defined status codes are reported
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_status_ff == STATUS_NOT_CHECKED ||
                        rsp_status_ff == STATUS_INVALID ||
                        rsp_status_ff == STATUS_VALID))
      else $error("undefined status code");

   // a pending varint never runs past ten bytes outside the error phase
   a_varint_len: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_ERROR) |-> (idx_ff <= VARINT_LAST_IDX))
      else $error("varint byte index out of range");
`endif

endmodule
`default_nettype wire
